// ===== sv/raid5_stripe_and_rebuild_macros.svh =====
// Assertion macros shared by the stripe/rebuild RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RAID5_STRIPE_AND_REBUILD_MACROS_SVH
`define RAID5_STRIPE_AND_REBUILD_MACROS_SVH

// same-cycle implication
`define RD5_ASSERT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rd5 check failed");

// next-cycle implication
`define RD5_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rd5 check failed");

`endif

// ===== sv/rd5_pkg.sv =====
// Shared types and constants for the four-disk stripe/rebuild block.
// No dependencies.
package rd5_pkg;

  localparam int unsigned NUM_DISKS = 4;
  localparam int unsigned NUM_DATA  = 3;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] disk_idx_t;

  localparam logic MODE_STRIPE  = 1'b0;
  localparam logic MODE_REBUILD = 1'b1;

  localparam disk_idx_t LAST_DISK = 2'd3;

  typedef struct packed {
    logic      mode;
    disk_idx_t pdisk;
  } merge_ctl_t;

endpackage

// ===== sv/rd5_if.sv =====
// Handshake channels of the stripe/rebuild block: stripe items, results, config.
// Depends on rd5_pkg.
interface rd5_item_if;
  logic          valid;
  logic          ready;
  logic          mode;
  logic          restart;
  rd5_pkg::byte_t in_byte_0;
  rd5_pkg::byte_t in_byte_1;
  rd5_pkg::byte_t in_byte_2;

  modport source (output valid, mode, restart, in_byte_0, in_byte_1, in_byte_2,
                  input ready);
  modport sink   (input valid, mode, restart, in_byte_0, in_byte_1, in_byte_2,
                  output ready);
endinterface

interface rd5_result_if;
  logic          valid;
  logic          ready;
  rd5_pkg::byte_t byte_0;
  rd5_pkg::byte_t byte_1;
  rd5_pkg::byte_t byte_2;
  rd5_pkg::byte_t byte_3;

  modport source (output valid, byte_0, byte_1, byte_2, byte_3, input ready);
  modport sink   (input valid, byte_0, byte_1, byte_2, byte_3, output ready);
endinterface

interface rd5_cfg_if;
  logic                 valid;
  logic                 ready;
  rd5_pkg::disk_idx_t   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/raid5_stripe_and_rebuild.sv =====
// Top level: four-disk striping with rotating parity and single-disk rebuild.
// Depends on rd5_pkg, rd5_if, rd5_lane, rd5_merge and the macros header.
//
//   channel     role    payload
//   stripe_in   sink    mode, restart, in_byte_0..2
//   stripe_out  source  byte_0..3
//   cfg         sink    data = missing_disk
//
// One item per cycle; a result appears in the cycle after its item is taken.
// The rate is set by the single output register: a new item enters whenever
// that register is empty or is being drained in the same cycle.
// Synchronous reset clears the phase, missing_disk and the output valid flag.
// A stall on stripe_out holds the result and drops stripe_in.ready.
`include "raid5_stripe_and_rebuild_macros.svh"

module raid5_stripe_and_rebuild (
  input  logic         clk,
  input  logic         rst,
  rd5_item_if.sink     stripe_in,
  rd5_result_if.source stripe_out,
  rd5_cfg_if.sink      cfg
);

  rd5_pkg::disk_idx_t  phase;
  rd5_pkg::disk_idx_t  missing_disk;
  rd5_pkg::disk_idx_t  phase_used;
  rd5_pkg::disk_idx_t  lane_sel;
  rd5_pkg::merge_ctl_t ctl;
  rd5_pkg::byte_t      disk [rd5_pkg::NUM_DISKS];
  rd5_pkg::byte_t      res  [rd5_pkg::NUM_DISKS];
  logic                out_valid;
  logic                out_mode;
  logic                acc;

  assign cfg.ready       = 1'b1;
  assign stripe_in.ready = !out_valid || stripe_out.ready;
  assign acc             = stripe_in.valid && stripe_in.ready;

  assign phase_used = stripe_in.restart ? 2'd0 : phase;
  assign ctl.mode   = stripe_in.mode;
  assign ctl.pdisk  = rd5_pkg::disk_idx_t'(rd5_pkg::LAST_DISK - phase_used);
  assign lane_sel   = (stripe_in.mode == rd5_pkg::MODE_STRIPE) ? ctl.pdisk : missing_disk;

  for (genvar g = 0; g < rd5_pkg::NUM_DISKS; g++) begin : g_lane
    rd5_lane u_lane (
      .lane_id (rd5_pkg::disk_idx_t'(g)),
      .sel     (lane_sel),
      .b0      (stripe_in.in_byte_0),
      .b1      (stripe_in.in_byte_1),
      .b2      (stripe_in.in_byte_2),
      .disk    (disk[g])
    );
  end

  rd5_merge u_merge (
    .ctl  (ctl),
    .disk (disk),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      missing_disk <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        missing_disk <= cfg.data;
      end
      if (acc) begin
        phase     <= rd5_pkg::disk_idx_t'(phase_used + 2'd1);
        out_valid <= 1'b1;
      end else if (stripe_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stripe_out.byte_0 <= res[0];
      stripe_out.byte_1 <= res[1];
      stripe_out.byte_2 <= res[2];
      stripe_out.byte_3 <= res[3];
      out_mode          <= stripe_in.mode;
    end
  end

  assign stripe_out.valid = out_valid;

  `RD5_ASSERT_NEXT(a_restart_phase, clk, rst, acc && stripe_in.restart, phase == 2'd1)
  `RD5_ASSERT_NEXT(a_phase_hold, clk, rst, !acc, $stable(phase))
  `RD5_ASSERT_NEXT(a_result_follows, clk, rst, acc, out_valid)
  `RD5_ASSERT(a_stripe_parity, clk, rst, out_valid && out_mode == rd5_pkg::MODE_STRIPE,
    (stripe_out.byte_0 ^ stripe_out.byte_1 ^ stripe_out.byte_2 ^ stripe_out.byte_3) == 8'd0)
  `RD5_ASSERT(a_rebuild_zero, clk, rst, out_valid && out_mode == rd5_pkg::MODE_REBUILD,
    stripe_out.byte_3 == 8'd0)

endmodule

// ===== sv/rd5_lane.sv =====
// One disk lane: places a data byte or the XOR of the three input bytes.
// Depends on rd5_pkg.
module rd5_lane (
  input  rd5_pkg::disk_idx_t lane_id,
  input  rd5_pkg::disk_idx_t sel,
  input  rd5_pkg::byte_t     b0,
  input  rd5_pkg::byte_t     b1,
  input  rd5_pkg::byte_t     b2,
  output rd5_pkg::byte_t     disk
);

  rd5_pkg::disk_idx_t idx;
  logic               above;

  assign above = (lane_id > sel);
  assign idx   = rd5_pkg::disk_idx_t'(lane_id - {1'b0, above});

  always_comb begin
    if (lane_id == sel) begin
      disk = b0 ^ b1 ^ b2;
    end else begin
      case (idx)
        2'd0:    disk = b0;
        2'd1:    disk = b1;
        default: disk = b2;
      endcase
    end
  end

endmodule

// ===== sv/rd5_merge.sv =====
// Merge stage: maps the four lane bytes to the result item.
// Depends on rd5_pkg.
module rd5_merge (
  input  rd5_pkg::merge_ctl_t ctl,
  input  rd5_pkg::byte_t      disk [rd5_pkg::NUM_DISKS],
  output rd5_pkg::byte_t      res  [rd5_pkg::NUM_DISKS]
);

  always_comb begin
    if (ctl.mode == rd5_pkg::MODE_STRIPE) begin
      for (int d = 0; d < rd5_pkg::NUM_DISKS; d++) begin
        res[d] = disk[d];
      end
    end else begin
      for (int k = 0; k < rd5_pkg::NUM_DATA; k++) begin
        if (2'(k) >= ctl.pdisk) begin
          res[k] = disk[k + 1];
        end else begin
          res[k] = disk[k];
        end
      end
      res[rd5_pkg::NUM_DISKS - 1] = '0;
    end
  end

endmodule
